@@ design/mphu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Modular polynomial hash unit package
// Shared widths, operation and register codes, and the types passed between
// the sequencer and the top level.
// ----------------------------------------------------------------------------
package mphu_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned BITS_W = 5;
  localparam int unsigned CNT_W  = 6;

  localparam logic [1:0] OP_APPEND   = 2'd0;
  localparam logic [1:0] OP_CONCAT   = 2'd1;
  localparam logic [1:0] OP_SUBTRACT = 2'd2;

  localparam logic CFG_SYMBOL_BITS = 1'b0;
  localparam logic CFG_MODULUS     = 1'b1;

  localparam logic [BITS_W-1:0] SYMBOL_BITS_RST = 5'd8;
  localparam logic [HASH_W-1:0] MODULUS_RST     = 32'd787;

  typedef struct packed {
    logic [1:0]        operation;
    logic [SYM_W-1:0]  symbol;
    logic              first;
    logic [HASH_W-1:0] hash_a;
    logic [HASH_W-1:0] hash_b;
    logic [HASH_W-1:0] length;
  } mphu_item_t;

  typedef struct packed {
    logic [BITS_W-1:0] symbol_bits;
    logic [HASH_W-1:0] modulus;
  } mphu_cfg_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [HASH_W-1:0] value;
  } mphu_status_t;

endpackage
`default_nettype wire

@@ design/mphu_mod_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Modular step unit
// Computes (2*acc + addend) mod m or (acc + addend) mod m for operands below m.
// ----------------------------------------------------------------------------
module mphu_mod_step
  import mphu_pkg::*;
(
  input  wire logic [HASH_W-1:0] acc_i,
  input  wire logic [HASH_W-1:0] addend_i,
  input  wire logic              dbl_i,
  input  wire logic [HASH_W-1:0] modulus_i,
  output logic [HASH_W-1:0]      result_o
);

  logic [HASH_W+2:0] sum;
  logic [HASH_W+2:0] m1;
  logic [HASH_W+2:0] m2;
  logic [HASH_W+2:0] diff1;
  logic [HASH_W+2:0] diff2;

  always_comb begin
    sum   = (dbl_i ? {2'b00, acc_i, 1'b0} : {3'b000, acc_i}) + {3'b000, addend_i};
    m1    = {3'b000, modulus_i};
    m2    = {2'b00, modulus_i, 1'b0};
    diff1 = sum - m1;
    diff2 = sum - m2;
    if (sum >= m2) begin
      result_o = diff2[HASH_W-1:0];
    end else if (sum >= m1) begin
      result_o = diff1[HASH_W-1:0];
    end else begin
      result_o = sum[HASH_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ design/mphu_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Hash sequencer
// Drives the shared modular step unit through reductions, shifts by the base,
// bit-serial multiplications and square-and-multiply powers.
// ----------------------------------------------------------------------------
module mphu_engine
  import mphu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire mphu_item_t item_i,
  input  wire mphu_cfg_t  cfg_i,
  input  wire logic       out_free_i,
  output mphu_status_t    status_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RUN   = 4'd1;
  localparam logic [3:0] ST_H_SHF = 4'd2;
  localparam logic [3:0] ST_S_RED = 4'd3;
  localparam logic [3:0] ST_ADD   = 4'd4;
  localparam logic [3:0] ST_P_BIT = 4'd5;
  localparam logic [3:0] ST_P_MUL = 4'd6;
  localparam logic [3:0] ST_P_NXT = 4'd7;
  localparam logic [3:0] ST_A_MUL = 4'd8;
  localparam logic [3:0] ST_B_RED = 4'd9;
  localparam logic [3:0] ST_NEG   = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  logic [3:0]        state_q, state_d;
  logic [3:0]        ret_q, ret_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [BITS_W-1:0] bit_q, bit_d;
  logic              started_q, started_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [HASH_W-1:0] acc_q, acc_d;
  logic [HASH_W-1:0] mcand_q, mcand_d;
  logic [HASH_W-1:0] mplier_q, mplier_d;
  logic [HASH_W-1:0] tmp_q, tmp_d;
  mphu_item_t        item_q, item_d;

  logic [HASH_W-1:0] one;
  logic [HASH_W-1:0] step_add;
  logic              step_dbl;
  logic [HASH_W-1:0] step_res;
  logic              done;

  assign one      = (cfg_i.modulus == 32'd1) ? '0 : 32'd1;
  assign step_dbl = (state_q != ST_ADD);
  assign step_add = (state_q == ST_ADD) ? tmp_q : (mplier_q[HASH_W-1] ? mcand_q : '0);

  mphu_mod_step u_step (
    .acc_i     (acc_q),
    .addend_i  (step_add),
    .dbl_i     (step_dbl),
    .modulus_i (cfg_i.modulus),
    .result_o  (step_res)
  );

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    cnt_d     = cnt_q;
    bit_d     = bit_q;
    started_d = started_q;
    hash_d    = hash_q;
    acc_d     = acc_q;
    mcand_d   = mcand_q;
    mplier_d  = mplier_q;
    tmp_d     = tmp_q;
    item_d    = item_q;
    done      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          item_d = item_i;
          if (cfg_i.modulus == '0) begin
            acc_d   = '0;
            state_d = ST_DONE;
          end else if (item_i.operation == OP_APPEND) begin
            acc_d    = '0;
            mcand_d  = one;
            mplier_d = item_i.first ? '0 : hash_q;
            cnt_d    = CNT_W'(HASH_W);
            ret_d    = ST_H_SHF;
            state_d  = ST_RUN;
          end else if (item_i.operation == OP_CONCAT || item_i.operation == OP_SUBTRACT) begin
            acc_d     = one;
            bit_d     = '1;
            started_d = 1'b0;
            state_d   = ST_P_BIT;
          end else begin
            acc_d   = '0;
            state_d = ST_DONE;
          end
        end
      end
      ST_RUN: begin
        acc_d    = step_res;
        mplier_d = {mplier_q[HASH_W-2:0], 1'b0};
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = ret_q;
        end
      end
      ST_H_SHF: begin
        mplier_d = '0;
        cnt_d    = {1'b0, cfg_i.symbol_bits};
        ret_d    = ST_S_RED;
        state_d  = (cfg_i.symbol_bits == '0) ? ST_S_RED : ST_RUN;
      end
      ST_S_RED: begin
        tmp_d    = acc_q;
        acc_d    = '0;
        mcand_d  = one;
        mplier_d = {item_q.symbol, {(HASH_W-SYM_W){1'b0}}};
        cnt_d    = CNT_W'(SYM_W);
        ret_d    = ST_ADD;
        state_d  = ST_RUN;
      end
      ST_ADD: begin
        acc_d   = step_res;
        state_d = ST_DONE;
      end
      ST_P_BIT: begin
        if (started_q) begin
          mcand_d  = acc_q;
          mplier_d = acc_q;
          acc_d    = '0;
          cnt_d    = CNT_W'(HASH_W);
          ret_d    = ST_P_MUL;
          state_d  = ST_RUN;
        end else begin
          state_d = ST_P_MUL;
        end
      end
      ST_P_MUL: begin
        if (item_q.length[bit_q]) begin
          started_d = 1'b1;
          mplier_d  = '0;
          cnt_d     = {1'b0, cfg_i.symbol_bits};
          ret_d     = ST_P_NXT;
          state_d   = (cfg_i.symbol_bits == '0) ? ST_P_NXT : ST_RUN;
        end else begin
          state_d = ST_P_NXT;
        end
      end
      ST_P_NXT: begin
        if (bit_q == '0) begin
          state_d = ST_A_MUL;
        end else begin
          bit_d   = bit_q - 1'b1;
          state_d = ST_P_BIT;
        end
      end
      ST_A_MUL: begin
        mcand_d  = acc_q;
        mplier_d = item_q.hash_a;
        acc_d    = '0;
        cnt_d    = CNT_W'(HASH_W);
        ret_d    = ST_B_RED;
        state_d  = ST_RUN;
      end
      ST_B_RED: begin
        tmp_d    = acc_q;
        acc_d    = '0;
        mcand_d  = one;
        mplier_d = item_q.hash_b;
        cnt_d    = CNT_W'(HASH_W);
        ret_d    = (item_q.operation == OP_SUBTRACT) ? ST_NEG : ST_ADD;
        state_d  = ST_RUN;
      end
      ST_NEG: begin
        tmp_d   = (tmp_q == '0) ? '0 : cfg_i.modulus - tmp_q;
        state_d = ST_ADD;
      end
      ST_DONE: begin
        if (out_free_i) begin
          done = 1'b1;
          if (item_q.operation == OP_APPEND) begin
            hash_d = acc_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= ST_IDLE;
      cnt_q     <= '0;
      bit_q     <= '0;
      started_q <= 1'b0;
      hash_q    <= '0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      cnt_q     <= cnt_d;
      bit_q     <= bit_d;
      started_q <= started_d;
      hash_q    <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    tmp_q    <= tmp_d;
    item_q   <= item_d;
  end

  assign status_o.busy  = (state_q != ST_IDLE);
  assign status_o.done  = done;
  assign status_o.value = acc_q;

endmodule
`default_nettype wire

@@ design/modular_polynomial_hash_unit_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Modular polynomial hash unit
// Karp-Rabin hash with base 2^symbol_bits: byte append, concatenate and
// subtract-prefix operations under a configured modulus.
// ----------------------------------------------------------------------------
// One item is in work at a time and the input is stalled until its result is
// handed to the output register. All arithmetic but the negation for subtract
// runs through one modular step unit that doubles and adds, or only adds, with
// a compare-and-subtract, so a modular multiplication runs bit-serially over
// the multiplier bits and a shift by the base doubles symbol_bits times. An
// append reduces the prefix hash, shifts it by the base, reduces the symbol
// and adds. Concatenate and subtract scan the exponent bits from the top,
// squaring at each bit below the top set bit and shifting at each set bit.
// Operation code 3 and a zero modulus return 0.
module modular_polynomial_hash_unit_core
  import mphu_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        operation_i,
  input  wire logic [SYM_W-1:0]  symbol_i,
  input  wire logic              first_i,
  input  wire logic [HASH_W-1:0] hash_a_i,
  input  wire logic [HASH_W-1:0] hash_b_i,
  input  wire logic [HASH_W-1:0] length_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [HASH_W-1:0]      hash_value_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_index_i,
  input  wire logic [HASH_W-1:0] cfg_data_i
);

  mphu_cfg_t         cfg_q;
  mphu_item_t        item;
  mphu_status_t      status;
  logic              in_xfer;
  logic              out_free;
  logic              out_valid_q;
  logic [HASH_W-1:0] out_hash_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.symbol_bits <= SYMBOL_BITS_RST;
      cfg_q.modulus     <= MODULUS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SYMBOL_BITS: cfg_q.symbol_bits <= cfg_data_i[BITS_W-1:0];
        CFG_MODULUS:     cfg_q.modulus     <= cfg_data_i;
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  assign item.operation = operation_i;
  assign item.symbol    = symbol_i;
  assign item.first     = first_i;
  assign item.hash_a    = hash_a_i;
  assign item.hash_b    = hash_b_i;
  assign item.length    = length_i;

  assign in_stall_o = status.busy;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  mphu_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer),
    .item_i     (item),
    .cfg_i      (cfg_q),
    .out_free_i (out_free),
    .status_o   (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (status.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status.done) begin
      out_hash_q <= status.value;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_hash_q;

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("Input was not stalled after a transfer.");

  a_done_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.done |-> out_free)
    else $error("Result produced while the output register was occupied.");

  a_result_from_engine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(status.done))
    else $error("Output became valid without a finished item.");

  a_done_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.done |=> !status.busy)
    else $error("Sequencer stayed busy after delivering a result.");

endmodule
`default_nettype wire

@@ test/modular_polynomial_hash_unit_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular polynomial hash unit testbench
// Drives append, concatenate, subtract-prefix and unused items under many
// modulus and base settings, predicts every hash in the bench, and checks each
// result transfer in order against the predicted value.
// ----------------------------------------------------------------------------
module modular_polynomial_hash_unit_core_tb
  import mphu_pkg::*;
;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam longint      CYCLE_LIMIT = 12_000_000;
  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned TAIL_CYCLES = 2500;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [1:0]        operation_i = OP_APPEND;
  logic [SYM_W-1:0]  symbol_i    = '0;
  logic              first_i     = 1'b0;
  logic [HASH_W-1:0] hash_a_i    = '0;
  logic [HASH_W-1:0] hash_b_i    = '0;
  logic [HASH_W-1:0] length_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b1;
  logic [HASH_W-1:0] hash_value_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = CFG_SYMBOL_BITS;
  logic [HASH_W-1:0] cfg_data_i  = '0;

  logic [BITS_W-1:0] tracked_bits    = SYMBOL_BITS_RST;
  logic [HASH_W-1:0] tracked_modulus = MODULUS_RST;
  logic [HASH_W-1:0] tracked_prefix  = '0;
  logic [HASH_W-1:0] last_prediction = '0;
  logic [HASH_W-1:0] pending_hashes[$];

  bit          idle_on     = 1'b1;
  bit          hold_toggle = 1'b0;
  bit          hold_seen   = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned pause_left  = 0;
  int unsigned items_sent  = 0;
  int unsigned fail_count  = 0;
  longint      cycle_count = 0;

  modular_polynomial_hash_unit_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .symbol_i    (symbol_i),
    .first_i     (first_i),
    .hash_a_i    (hash_a_i),
    .hash_b_i    (hash_b_i),
    .length_i    (length_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hash_value_o(hash_value_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [63:0] base_power_mod(input logic [BITS_W-1:0] bits,
                                                 input logic [HASH_W-1:0] expo,
                                                 input logic [63:0] m);
    logic [63:0]       acc;
    logic [63:0]       sq;
    logic [HASH_W-1:0] rest;
    acc  = 64'd1 % m;
    sq   = (64'd1 << bits) % m;
    rest = expo;
    while (rest != 0) begin
      if (rest[0]) begin
        acc = (acc * sq) % m;
      end
      sq   = (sq * sq) % m;
      rest = rest >> 1;
    end
    return acc;
  endfunction

  function automatic logic [HASH_W-1:0] predict_hash(input mphu_item_t it);
    logic [63:0] m;
    logic [63:0] h;
    logic [63:0] p;
    logic [63:0] t;
    logic [63:0] r;
    m = {32'd0, tracked_modulus};
    r = '0;
    case (it.operation)
      OP_APPEND: begin
        h = it.first ? 64'd0 : {32'd0, tracked_prefix};
        if (m != 0) begin
          p = base_power_mod(tracked_bits, 32'd1, m);
          r = ({56'd0, it.symbol} + (h * p) % m) % m;
        end
        tracked_prefix = r[HASH_W-1:0];
      end
      OP_CONCAT, OP_SUBTRACT: begin
        if (m != 0) begin
          p = base_power_mod(tracked_bits, it.length, m);
          t = ({32'd0, it.hash_a} * p) % m;
          if (it.operation == OP_CONCAT) begin
            r = ({32'd0, it.hash_b} + t) % m;
          end else begin
            r = ({32'd0, it.hash_b} + m - t) % m;
          end
        end
      end
      default: r = '0;
    endcase
    return r[HASH_W-1:0];
  endfunction

  function automatic mphu_item_t make_item(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                                           input logic first, input logic [HASH_W-1:0] a,
                                           input logic [HASH_W-1:0] b,
                                           input logic [HASH_W-1:0] len);
    mphu_item_t it;
    it.operation = op;
    it.symbol    = sym;
    it.first     = first;
    it.hash_a    = a;
    it.hash_b    = b;
    it.length    = len;
    return it;
  endfunction

  function automatic logic [HASH_W-1:0] below_modulus();
    return (tracked_modulus > 1) ? $urandom % tracked_modulus : $urandom;
  endfunction

  // Every call starts and ends in the time step of a rising edge.
  task automatic send_item(input mphu_item_t it);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= it.operation;
    symbol_i    <= it.symbol;
    first_i     <= it.first;
    hash_a_i    <= it.hash_a;
    hash_b_i    <= it.hash_b;
    length_i    <= it.length;
    do @(posedge clk_i); while (in_stall_o);
    last_prediction = predict_hash(it);
    pending_hashes.push_back(last_prediction);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_hashes.size() != 0);
  endtask

  task automatic write_settings(input logic [HASH_W-1:0] bits_word,
                                input logic [HASH_W-1:0] mod_word);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_SYMBOL_BITS;
    cfg_data_i  <= bits_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracked_bits = bits_word[BITS_W-1:0];
    cfg_index_i <= CFG_MODULUS;
    cfg_data_i  <= mod_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracked_modulus = mod_word;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_random_settings();
    logic [HASH_W-1:0] bits_word;
    logic [HASH_W-1:0] mod_word;
    bits_word = $urandom;
    bits_word[BITS_W-1:0] = ($urandom_range(0, 15) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
    case ($urandom_range(0, 9))
      0:       mod_word = 32'd2;
      1:       mod_word = 32'hFFFF_FFFF;
      2:       mod_word = $urandom_range(0, 1);
      3, 4, 5: mod_word = $urandom_range(2, 1000);
      default: mod_word = $urandom;
    endcase
    write_settings(bits_word, mod_word);
  endtask

  // A string is hashed symbol by symbol, then its prefix hashes are combined.
  task automatic run_string_sequence();
    logic [HASH_W-1:0] prefixes[$];
    int unsigned       n;
    int unsigned       i;
    int unsigned       j;
    logic [HASH_W-1:0] len;
    n = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      send_item(make_item(OP_APPEND, SYM_W'($urandom), k == 0, $urandom, $urandom, $urandom));
      prefixes.push_back(last_prediction);
    end
    i = $urandom_range(0, n - 1);
    j = $urandom_range(i, n - 1);
    send_item(make_item(OP_SUBTRACT, SYM_W'($urandom), 1'($urandom), prefixes[i], prefixes[j],
                        j - i));
    len = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 40);
    send_item(make_item(OP_CONCAT, SYM_W'($urandom), 1'($urandom), prefixes[i], below_modulus(),
                        len));
  endtask

  task automatic send_noise();
    logic [HASH_W-1:0] len;
    repeat ($urandom_range(1, 3)) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 300);
      send_item(make_item(2'($urandom_range(0, 3)), SYM_W'($urandom), 1'($urandom), $urandom,
                          $urandom, len));
    end
  endtask

  task automatic test_reset_settings();
    send_item(make_item(OP_APPEND, 8'h00, 1'b1, '0, '0, '0));
    send_item(make_item(OP_APPEND, 8'hFF, 1'b0, '0, '0, '0));
    send_item(make_item(OP_APPEND, 8'h80, 1'b0, '0, '0, '0));
    send_item(make_item(OP_APPEND, 8'hFF, 1'b1, '0, '0, '0));
    send_item(make_item(OP_CONCAT, 8'h00, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
    send_item(make_item(OP_SUBTRACT, 8'h00, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF));
    send_item(make_item(OP_CONCAT, 8'h00, 1'b0, 32'd5, 32'd7, 32'd1));
    send_item(make_item(OP_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_item(OP_APPEND, 8'h01, 1'b0, '0, '0, '0));
  endtask

  task automatic test_setting_extremes();
    write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(make_item(OP_APPEND, 8'hFF, 1'b1, '0, '0, '0));
    send_item(make_item(OP_APPEND, 8'hFF, 1'b0, '0, '0, '0));
    send_item(make_item(OP_APPEND, 8'hFF, 1'b0, '0, '0, '0));
    send_item(make_item(OP_SUBTRACT, 8'h00, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF));
    send_item(make_item(OP_CONCAT, 8'h00, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    // The running hash now lies above the new modulus.
    write_settings(32'd1, 32'd787);
    send_item(make_item(OP_APPEND, 8'h55, 1'b0, '0, '0, '0));
    write_settings(32'd0, 32'd2);
    send_item(make_item(OP_APPEND, 8'h01, 1'b1, '0, '0, '0));
    send_item(make_item(OP_CONCAT, 8'h00, 1'b0, 32'd1, 32'd1, 32'hFFFF_FFFF));
    write_settings(32'hFFFF_FFE0, 32'd0);
    send_item(make_item(OP_APPEND, 8'hFF, 1'b0, '0, '0, '0));
    send_item(make_item(OP_CONCAT, 8'h00, 1'b0, 32'd3, 32'd9, 32'd4));
    send_item(make_item(OP_SUBTRACT, 8'h00, 1'b0, 32'd3, 32'd9, 32'd4));
    send_item(make_item(OP_UNUSED, 8'h00, 1'b0, 32'd3, 32'd9, 32'd4));
    write_settings(32'd5, 32'd1);
    send_item(make_item(OP_APPEND, 8'h7F, 1'b1, '0, '0, '0));
    send_item(make_item(OP_SUBTRACT, 8'h00, 1'b0, 32'd8, 32'd2, 32'd17));
  endtask

  task automatic test_random_phases();
    int unsigned target;
    for (int phase = 0; phase < 8; phase++) begin
      write_random_settings();
      idle_on = (phase != 3);
      target  = items_sent + 110;
      while (items_sent < target) begin
        if ($urandom_range(0, 4) != 0) begin
          run_string_sequence();
        end else begin
          send_noise();
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // The receiver holds off while items keep coming, so the input stalls.
  task automatic test_output_backpressure();
    write_settings(32'd8, $urandom_range(2, 100000));
    idle_on     = 1'b0;
    hold_toggle = ~hold_toggle;
    repeat (10) begin
      send_item(make_item(OP_APPEND, SYM_W'($urandom), $urandom_range(0, 3) == 0, '0, '0, '0));
    end
    send_item(make_item(OP_CONCAT, 8'h00, 1'b0, below_modulus(), below_modulus(), 32'd9));
    idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat (2) run_string_sequence();
      wait_drained();
    end
  endtask

  always @(posedge clk_i) begin : drive_out_stall
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = LONG_HOLD;
    end
    if (out_valid_o && !out_stall_i) begin
      pause_left = idle_on ? $urandom_range(0, 19) : 0;
    end else if (out_valid_o && pause_left != 0) begin
      pause_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
    end
    out_stall_i <= (hold_left != 0) || (pause_left != 0);
  end

  always @(posedge clk_i) begin : check_results
    logic [HASH_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hashes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("Unexpected result transfer: hash_value %h", hash_value_o);
        end
      end else begin
        want = pending_hashes.pop_front();
        if (hash_value_o !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Hash mismatch: expected %h, actual %h", want, hash_value_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_settings();
    test_setting_extremes();
    test_output_backpressure();
    test_drain_pause();
    test_random_phases();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
